FILE: hdl/sorted_set_table_core_macros.svh
// Assertion macros for the sorted set table core.
`ifndef SORTED_SET_TABLE_CORE_MACROS_SVH
`define SORTED_SET_TABLE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is high.
`define SST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds through reset.
`define SST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SST_ASSERT(lbl, clk, rst, prop, msg)
`define SST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/sst_pkg.sv
// Shared field widths, codes and cell control types for the sorted set table.
package sst_pkg;

   localparam int ACTION_BITS     = 3;
   localparam int FIELD_KEY_BITS  = 32;
   localparam int POS_BITS        = 6;
   localparam int STATUS_BITS     = 3;
   localparam int COUNT_BITS      = 7;

   localparam logic [ACTION_BITS-1:0] ACT_INSERT  = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_LOOKUP  = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_DEL_KEY = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_DEL_IDX = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_READ    = 3'd4;

   localparam logic [STATUS_BITS-1:0] STAT_DONE      = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_PRESENT   = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_RANGE     = 3'd4;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic capture;   // latch compare flags against the incoming request
      logic insert;    // open a gap at the insertion point and load the key
      logic remove;    // close the gap at the removal point
      logic use_pos;   // removal point comes from the index, not the key
   } cell_cmd_type;

   // Flags each cell reports back: lt, eq and sel are registered at capture, fge is derived from lt.
   typedef struct packed {
      logic lt;        // valid and holds a smaller key
      logic eq;        // valid and holds the request key
      logic sel;       // valid and sits at the requested index
      logic fge;       // first cell whose key is not smaller
   } cell_flag_type;

endpackage

FILE: hdl/sst_cell.sv
// One table slot: holds a key, compares it with the request and shifts with its neighbours.
module sst_cell import sst_pkg::*; #(
   parameter int KEY_BITS   = 32,
   parameter int DEPTH      = 64,
   parameter int CELL_INDEX = 0,
   localparam int CW        = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  cell_cmd_type        cmd,
   input  logic [KEY_BITS-1:0] req_key,
   input  logic [POS_BITS-1:0] req_pos,
   input  logic [CW-1:0]       count,
   input  logic [KEY_BITS-1:0] ins_key,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic                left_lt,
   input  logic [KEY_BITS-1:0] right_key,
   output logic [KEY_BITS-1:0] key,
   output cell_flag_type       flags
);

   localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                lt_ff, lt_in;
   logic                eq_ff, eq_in;
   logic                sel_ff, sel_in;
   logic                gep_ff, gep_in;
   logic                valid;
   logic                fge;

   assign valid = CW'(CELL_INDEX) < count;
   assign fge   = !lt_ff && left_lt;

   always_comb begin
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      sel_in = sel_ff;
      gep_in = gep_ff;
      if (cmd.capture) begin
         lt_in  = valid && (key_ff < req_key);
         eq_in  = valid && (key_ff == req_key);
         sel_in = valid && (CMPW'(CELL_INDEX) == CMPW'(req_pos));
         gep_in = CMPW'(CELL_INDEX) >= CMPW'(req_pos);
      end
   end

   always_comb begin
      key_in = key_ff;
      if (cmd.insert) begin
         if (fge) begin
            key_in = ins_key;
         end else if (!lt_ff) begin
            key_in = left_key;
         end
      end else if (cmd.remove) begin
         if (cmd.use_pos ? gep_ff : !lt_ff) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
      sel_ff <= sel_in;
      gep_ff <= gep_in;
   end

   assign key       = key_ff;
   assign flags.lt  = lt_ff;
   assign flags.eq  = eq_ff;
   assign flags.sel = sel_ff;
   assign flags.fge = fge;

endmodule

FILE: hdl/sorted_set_table_core.sv
// Sorted set table: a row of key cells kept in ascending order with a two-step controller.
//
// Holds up to DEPTH distinct keys in ascending unsigned order, one key per cell. On the
// transfer of a request each cell compares its key with the request key and index and
// registers the outcome; in the apply state, once the output register is free, the flags are
// combined into the answer while the cells shift right (insert) or left (delete) in parallel,
// so the time does not depend on how full the table is. The response sits in an output
// register; a new request is taken as soon as the previous one has been applied, even while
// its response waits to be taken. Actions are taken from req_tuser, and status returns on
// rsp_tuser. Slots hold no reset value; only the first entry_count slots are ever reported.
`include "sorted_set_table_core_macros.svh"

module sorted_set_table_core import sst_pkg::*; #(
   parameter int DEPTH    = 64,
   parameter int KEY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // key [31:0], position [37:32], zero [39:38]
   input  logic [2:0]  req_tuser,   // action [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // found_position [5:0], found_key [37:6],
                                    // entry_count [44:38], zero [47:45]
   output logic [2:0]  rsp_tuser    // status [2:0]
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_APPLY = 1'b1;

   logic                   state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ACTION_BITS-1:0] act_ff, act_in;
   logic [KEY_BITS-1:0]    k_ff, k_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;

   logic [STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [POS_BITS-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [FIELD_KEY_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [COUNT_BITS-1:0]     rsp_count_ff, rsp_count_in;

   logic          req_fire;
   logic          out_free;
   logic          apply_fire;
   cell_cmd_type  cmd;

   logic [KEY_BITS-1:0] key_vec [DEPTH];
   cell_flag_type       flag_vec [DEPTH];

   logic [DEPTH-1:0]    eq_bits;
   logic [DEPTH-1:0]    sel_bits;
   logic [IW-1:0]       eq_idx;
   logic [IW-1:0]       fge_idx;
   logic [KEY_BITS-1:0] eq_key;
   logic [KEY_BITS-1:0] sel_key;
   logic                hit;
   logic                in_range;
   logic                full;

   logic [STATUS_BITS-1:0] status_w;
   logic [POS_BITS-1:0]    fpos_w;
   logic [KEY_BITS-1:0]    fkey_w;
   logic                   ins_w;
   logic                   del_w;
   logic                   use_pos_w;
   logic [CW-1:0]          count_next;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign apply_fire = (state_ff == S_APPLY) && out_free;

   assign act_in = req_fire ? req_tuser : act_ff;
   assign k_in   = req_fire ? KEY_BITS'(req_tdata[FIELD_KEY_BITS-1:0]) : k_ff;
   assign pos_in = req_fire ? req_tdata[FIELD_KEY_BITS +: POS_BITS] : pos_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_fire) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Cell row
   assign cmd.capture = req_fire;
   assign cmd.insert  = apply_fire && ins_w;
   assign cmd.remove  = apply_fire && del_w;
   assign cmd.use_pos = use_pos_w;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sst_cell #(
         .KEY_BITS   (KEY_BITS),
         .DEPTH      (DEPTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .req_key   (KEY_BITS'(req_tdata[FIELD_KEY_BITS-1:0])),
         .req_pos   (req_tdata[FIELD_KEY_BITS +: POS_BITS]),
         .count     (count_ff),
         .ins_key   (k_ff),
         .left_key  ((i == 0) ? k_ff : key_vec[(i == 0) ? 0 : i - 1]),
         .left_lt   ((i == 0) ? 1'b1 : flag_vec[(i == 0) ? 0 : i - 1].lt),
         .right_key ((i == DEPTH - 1) ? key_vec[i] : key_vec[(i == DEPTH - 1) ? i : i + 1]),
         .key       (key_vec[i]),
         .flags     (flag_vec[i])
      );
   end

   // Gather answers from the row; each flag is set in at most one cell
   always_comb begin
      eq_bits  = '0;
      sel_bits = '0;
      eq_idx   = '0;
      fge_idx  = '0;
      eq_key   = '0;
      sel_key  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         eq_bits[i]  = flag_vec[i].eq;
         sel_bits[i] = flag_vec[i].sel;
         if (flag_vec[i].eq) begin
            eq_idx = eq_idx | IW'(i);
            eq_key = eq_key | key_vec[i];
         end
         if (flag_vec[i].fge) begin
            fge_idx = fge_idx | IW'(i);
         end
         if (flag_vec[i].sel) begin
            sel_key = sel_key | key_vec[i];
         end
      end
   end

   assign hit      = |eq_bits;
   assign in_range = |sel_bits;
   assign full     = (count_ff == CW'(DEPTH));

   always_comb begin
      status_w   = STAT_NOT_FOUND;
      fpos_w     = '0;
      fkey_w     = '0;
      ins_w      = 1'b0;
      del_w      = 1'b0;
      use_pos_w  = 1'b0;
      count_next = count_ff;
      unique case (act_ff)
         ACT_INSERT: begin
            if (hit) begin
               status_w = STAT_PRESENT;
               fpos_w   = POS_BITS'(eq_idx);
               fkey_w   = eq_key;
            end else if (full) begin
               status_w = STAT_FULL;
            end else begin
               status_w   = STAT_DONE;
               fpos_w     = POS_BITS'(fge_idx);
               fkey_w     = k_ff;
               ins_w      = 1'b1;
               count_next = count_ff + CW'(1);
            end
         end
         ACT_LOOKUP, ACT_DEL_KEY: begin
            if (hit) begin
               status_w = STAT_DONE;
               fpos_w   = POS_BITS'(eq_idx);
               fkey_w   = eq_key;
               if (act_ff == ACT_DEL_KEY) begin
                  del_w      = 1'b1;
                  count_next = count_ff - CW'(1);
               end
            end
         end
         ACT_DEL_IDX, ACT_READ: begin
            if (in_range) begin
               status_w = STAT_DONE;
               fpos_w   = pos_ff;
               fkey_w   = sel_key;
               if (act_ff == ACT_DEL_IDX) begin
                  del_w      = 1'b1;
                  use_pos_w  = 1'b1;
                  count_next = count_ff - CW'(1);
               end
            end else begin
               status_w = STAT_RANGE;
            end
         end
         default: status_w = STAT_NOT_FOUND;
      endcase
   end

   assign count_in     = apply_fire ? count_next : count_ff;
   assign rsp_valid_in = apply_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign rsp_status_in = apply_fire ? status_w : rsp_status_ff;
   assign rsp_pos_in    = apply_fire ? fpos_w : rsp_pos_ff;
   assign rsp_key_in    = apply_fire ? FIELD_KEY_BITS'(fkey_w) : rsp_key_ff;
   assign rsp_count_in  = apply_fire ? COUNT_BITS'(count_next) : rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      k_ff          <= k_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_key_ff, rsp_pos_ff};

   // Checks
   `SST_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CW'(DEPTH)), "entry count beyond depth")
   `SST_ASSERT(a_keys_distinct, clock, reset, (state_ff == S_APPLY) |-> $onehot0(eq_bits),
      "duplicate key matched in table")
   `SST_ASSERT(a_index_unique, clock, reset, (state_ff == S_APPLY) |-> $onehot0(sel_bits),
      "more than one cell selected by index")
   `SST_ASSERT(a_count_hold, clock, reset, !apply_fire |=> $stable(count_ff),
      "entry count changed without an applied request")

endmodule
